// ===== hw/rtl/b64e_pkg.sv =====
// ----------------------------------------------------------------------------
// b64e_pkg
// shared types, constants and the character table of the base64 encoder
// ----------------------------------------------------------------------------
package b64e_pkg;

    // input command codes (carried on s_tuser)
    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    // pad character '='
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // job queue between front and back, depth must be a power of two
    localparam int JOB_DEPTH = 4;
    localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
    localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    // position within the three byte group
    typedef enum logic [2:0] {
        PH_0 = 3'b001,
        PH_1 = 3'b010,
        PH_2 = 3'b100
    } phase_t;

    // one classified item: up to three characters, first in slot 0
    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][7:0] chars;
    } job_t;

    // six bit code to base64 alphabet character
    function automatic logic [7:0] b64_char(input logic [5:0] code);
        logic [7:0] c;
        begin
            c = {2'b00, code};
            if (code < 6'd26) begin
                b64_char = 8'(8'h41 + c);
            end else if (code < 6'd52) begin
                b64_char = 8'(8'h61 + c - 8'd26);
            end else if (code < 6'd62) begin
                b64_char = 8'(8'h30 + c - 8'd52);
            end else if (code == 6'd62) begin
                b64_char = 8'h2B;
            end else begin
                b64_char = 8'h2F;
            end
        end
    endfunction

endpackage

// ===== hw/rtl/b64e_front.sv =====
// ----------------------------------------------------------------------------
// b64e_front
// accepts items, tracks group position and builds character jobs
// ----------------------------------------------------------------------------
module b64e_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,
    input  logic               s_tuser,
    input  logic               q_full,
    output logic               q_push,
    output b64e_pkg::job_t     q_job
);

    b64e_pkg::phase_t phase_reg, phase_next;
    logic [5:0]       left_reg, left_next;
    logic             accept;
    logic             has_job;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept && has_job;

    always_comb begin
        phase_next  = phase_reg;
        left_next   = left_reg;
        has_job     = 1'b1;
        q_job.count = 2'd1;
        q_job.chars = '0;
        case (phase_reg)
            b64e_pkg::PH_1: begin
                if (s_tuser == b64e_pkg::CMD_FINISH) begin
                    q_job.count    = 2'd3;
                    q_job.chars[0] = b64e_pkg::b64_char(left_reg);
                    q_job.chars[1] = b64e_pkg::PAD_CHAR;
                    q_job.chars[2] = b64e_pkg::PAD_CHAR;
                    phase_next     = b64e_pkg::PH_0;
                    left_next      = '0;
                end else begin
                    q_job.chars[0] = b64e_pkg::b64_char(left_reg | {2'b00, s_tdata[7:4]});
                    phase_next     = b64e_pkg::PH_2;
                    left_next      = {s_tdata[3:0], 2'b00};
                end
            end
            b64e_pkg::PH_2: begin
                q_job.count = 2'd2;
                if (s_tuser == b64e_pkg::CMD_FINISH) begin
                    q_job.chars[0] = b64e_pkg::b64_char(left_reg);
                    q_job.chars[1] = b64e_pkg::PAD_CHAR;
                end else begin
                    q_job.chars[0] = b64e_pkg::b64_char(left_reg | {4'b0000, s_tdata[7:6]});
                    q_job.chars[1] = b64e_pkg::b64_char(s_tdata[5:0]);
                end
                phase_next = b64e_pkg::PH_0;
                left_next  = '0;
            end
            default: begin
                // start of group: finish here emits nothing
                if (s_tuser == b64e_pkg::CMD_FINISH) begin
                    has_job = 1'b0;
                end else begin
                    q_job.chars[0] = b64e_pkg::b64_char(s_tdata[7:2]);
                    phase_next     = b64e_pkg::PH_1;
                    left_next      = {s_tdata[1:0], 4'b0000};
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= b64e_pkg::PH_0;
            left_reg  <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

endmodule

// ===== hw/rtl/b64e_fifo.sv =====
// ----------------------------------------------------------------------------
// b64e_fifo
// short job queue between the front and back parts
// ----------------------------------------------------------------------------
module b64e_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  b64e_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output b64e_pkg::job_t head_job,
    output logic           empty
);

    b64e_pkg::job_t                     mem_reg [b64e_pkg::JOB_DEPTH];
    logic [b64e_pkg::JOB_PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [b64e_pkg::JOB_CNT_W-1:0]     count_reg, count_next;

    assign full     = (count_reg == b64e_pkg::JOB_CNT_W'(b64e_pkg::JOB_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hw/rtl/b64e_back.sv =====
// ----------------------------------------------------------------------------
// b64e_back
// walks the characters of the head job into the output register
// ----------------------------------------------------------------------------
module b64e_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  b64e_pkg::job_t head_job,
    input  logic           q_empty,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tlast
);

    logic [1:0] idx_reg;
    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic       m_tlast_reg;
    logic       load;
    logic       is_last;

    assign load     = !q_empty && (!m_tvalid_reg || m_tready);
    assign is_last  = (idx_reg == head_job.count - 2'd1);
    assign q_pop    = load && is_last;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (load) begin
                m_tvalid_reg <= 1'b1;
                idx_reg      <= is_last ? 2'd0 : idx_reg + 2'd1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= head_job.chars[idx_reg];
            m_tlast_reg <= is_last;
        end
    end

endmodule

// ===== hw/rtl/base64_stream_encoder.sv =====
// ----------------------------------------------------------------------------
// base64_stream_encoder
// streaming base64 encoder, up to one character per cycle, as m_tready allows, on the output
// ----------------------------------------------------------------------------
// path: the first character of an item passes the job queue and then the output register
// throughput: one output character per cycle while m_tready is high, set by the single
//   output register; a byte every cycle while the 4-entry job queue has room,
//   four characters per three bytes sustained, a finish adds up to three characters
// reset: synchronous active-low aresetn returns to group start and empties the queue
// ----------------------------------------------------------------------------
module base64_stream_encoder (
    input  logic       aclk,
    input  logic       aresetn,
    // input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] command: 0 encode byte, 1 finish and pad
    // output stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast    // final character caused by one input transaction
);

    // front to queue
    logic           q_push;
    b64e_pkg::job_t q_job;
    logic           q_full;
    // queue to back
    logic           q_pop;
    logic           q_empty;
    b64e_pkg::job_t head_job;

    // front: accepts a transaction, advances the group position and
    // turns it into a job of one to three characters, or none for a finish at group start
    b64e_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_job)
    );

    // job queue decouples input acceptance from output stalls
    b64e_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_job),
        .full     (q_full),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty)
    );

    // back: emits the head job one character per cycle while m_tready allows, tlast on its final one
    b64e_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== hw/rtl/b64e_checker.sv =====
// ----------------------------------------------------------------------------
// b64e_checker
// port level checks of the base64 encoder, bound to the top level
// ----------------------------------------------------------------------------
module b64e_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    logic legal_char;
    logic in_fire;

    assign legal_char = (m_tdata >= 8'h41 && m_tdata <= 8'h5A)
                     || (m_tdata >= 8'h61 && m_tdata <= 8'h7A)
                     || (m_tdata >= 8'h30 && m_tdata <= 8'h39)
                     || m_tdata == 8'h2B || m_tdata == 8'h2F || m_tdata == 8'h3D;
    assign in_fire = s_tvalid && s_tready && (s_tdata == s_tdata) && (s_tuser == s_tuser);

    // stalled output transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    // output empty right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // only alphabet or pad characters leave the block
    a_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> legal_char)
        else $error("illegal output character");

    // right after reset the output is not valid unless an input fired while reset was low
    a_cause: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid || $past(in_fire))
        else $error("output without input transaction");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== tb/b64e_checker.sv =====
// ----------------------------------------------------------------------------
// b64e_scoreboard
// watches both streams of the base64 encoder, predicts and compares the output
// ----------------------------------------------------------------------------
// every accepted input transaction is run through a local copy of the encoder
// (group position plus carried bits) and the characters it must produce are
// queued; every accepted output transaction is compared against the oldest one
// ----------------------------------------------------------------------------
module b64e_scoreboard (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] command
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] out_char
    input  logic       m_tlast,
    output int         fail_count,
    output int         pending_chars
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [8*64-1:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef enum logic [1:0] {
        GRP_START = 2'd0,
        GRP_ONE   = 2'd1,
        GRP_TWO   = 2'd2
    } grp_pos_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } enc_char_t;

    enc_char_t  expected_chars[$];
    enc_char_t  want;
    grp_pos_t   grp_pos;
    logic [5:0] carry_bits;
    int         mismatches;

    initial begin
        fail_count    = 0;
        pending_chars = 0;
        mismatches    = 0;
        grp_pos       = GRP_START;
        carry_bits    = '0;
    end

    function automatic logic [7:0] sextet_to_ascii(input logic [5:0] code);
        int idx;
        idx = 63 - int'(code);
        return B64_ALPHABET[8*idx +: 8];
    endfunction

    task automatic queue_char(input logic [7:0] ch, input logic last);
        expected_chars.push_back({ch, last});
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    // one input transaction: queue its characters and advance the group position
    task automatic encode_transaction(input logic cmd, input logic [7:0] b);
        logic [5:0] held;
        held = carry_bits;
        if (cmd == b64e_pkg::CMD_FINISH) begin
            case (grp_pos)
                GRP_ONE: begin
                    queue_char(sextet_to_ascii(held), 1'b0);
                    queue_char(b64e_pkg::PAD_CHAR, 1'b0);
                    queue_char(b64e_pkg::PAD_CHAR, 1'b1);
                end
                GRP_TWO: begin
                    queue_char(sextet_to_ascii(held), 1'b0);
                    queue_char(b64e_pkg::PAD_CHAR, 1'b1);
                end
                default: ;
            endcase
            grp_pos    = GRP_START;
            carry_bits = '0;
        end else begin
            case (grp_pos)
                GRP_ONE: begin
                    queue_char(sextet_to_ascii(held | {2'b00, b[7:4]}), 1'b1);
                    carry_bits = {b[3:0], 2'b00};
                    grp_pos    = GRP_TWO;
                end
                GRP_TWO: begin
                    queue_char(sextet_to_ascii(held | {4'b0000, b[7:6]}), 1'b0);
                    queue_char(sextet_to_ascii(b[5:0]), 1'b1);
                    carry_bits = '0;
                    grp_pos    = GRP_START;
                end
                default: begin
                    queue_char(sextet_to_ascii(b[7:2]), 1'b1);
                    carry_bits = {b[1:0], 4'b0000};
                    grp_pos    = GRP_ONE;
                end
            endcase
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_chars.delete();
            grp_pos    = GRP_START;
            carry_bits = '0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected char 0x%02h last %0b",
                                              m_tdata, m_tlast));
                end else begin
                    want = expected_chars.pop_front();
                    if (m_tdata !== want.ch) begin
                        report_mismatch($sformatf("char 0x%02h, expected 0x%02h",
                                                  m_tdata, want.ch));
                    end
                    if (m_tlast !== want.last) begin
                        report_mismatch($sformatf("tlast %0b, expected %0b on char 0x%02h",
                                                  m_tlast, want.last, want.ch));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                encode_transaction(s_tuser, s_tdata);
            end
        end
        fail_count    <= mismatches;
        pending_chars <= expected_chars.size();
    end

endmodule

// ===== tb/tb_base64_stream_encoder.sv =====
// ----------------------------------------------------------------------------
// tb_base64_stream_encoder
// stimulus and verdict for the streaming base64 encoder
// ----------------------------------------------------------------------------
// a directed opening covers padding after one and two bytes, finish at group
// start, extreme bytes and the '+' and '/' characters; random runs of bytes,
// most closed by a finish, follow. the sender works in bursts, the receiver
// stalls on its own pattern and, at the start and halfway through the random
// runs, holds off long enough to back up the input. checked by b64e_scoreboard
// ----------------------------------------------------------------------------
module tb_base64_stream_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTE_TARGET = 256;     // random data bytes before stopping
    localparam int LONG_HOLD   = 250;     // receiver hold-off, in cycles
    localparam int DRAIN_WAIT  = 10;      // latency margin after the last char
    localparam int CYCLE_LIMIT = 200000;

    logic       aclk;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;                 // [7:0] data_byte
    logic       s_tuser  = b64e_pkg::CMD_ENCODE;  // [0] command
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;                          // [7:0] out_char
    logic       m_tlast;

    int fail_count;
    int pending_chars;
    int cycle_count  = 0;
    int burst_left   = 1;
    int bytes_sent   = 0;
    bit hold_off_go  = 1'b0;              // one-shot request for the long hold-off

    base64_stream_encoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    b64e_scoreboard u_scoreboard (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending_chars (pending_chars)
    );

    // 20 ns clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // hard stop in case the block hangs
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("*** FAILED ***");
        $finish;
    end

    // offer one transaction and wait for it to be taken; between bursts the
    // sender drops tvalid for a random pause
    task automatic offer_item(input logic cmd, input logic [7:0] b);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (cmd == b64e_pkg::CMD_ENCODE) begin
            bytes_sent++;
        end
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    // mostly uniform bytes, with the all-zero and all-one patterns mixed in
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // receiver: stretches of always-ready, coin flip, mostly stalled and
    // alternating, plus the long hold-off when the stimulus asks for it
    initial begin : receiver
        int stretch;
        int mode;
        int k;
        while (!aresetn) @(posedge aclk);
        forever begin
            stretch = $urandom_range(5, 60);
            mode    = $urandom_range(0, 3);
            for (k = 0; k < stretch; k++) begin
                if (hold_off_go) begin
                    hold_off_go = 1'b0;
                    m_tready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge aclk);
                end else begin
                    case (mode)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= 1'($urandom_range(0, 1));
                        2:       m_tready <= ($urandom_range(0, 3) == 0);
                        default: m_tready <= k[0];
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    initial begin : stimulus
        int run_len;
        int i;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // finish at group start emits nothing, its byte is ignored
        offer_item(b64e_pkg::CMD_FINISH, 8'hA5);
        // one byte then finish: double pad
        offer_item(b64e_pkg::CMD_ENCODE, 8'h00);
        offer_item(b64e_pkg::CMD_FINISH, 8'hFF);
        // two bytes then finish: single pad
        offer_item(b64e_pkg::CMD_ENCODE, 8'hFF);
        offer_item(b64e_pkg::CMD_ENCODE, 8'hFF);
        offer_item(b64e_pkg::CMD_FINISH, 8'h00);
        // full group clears the carry, then finish twice with nothing to flush
        offer_item(b64e_pkg::CMD_ENCODE, 8'h00);
        offer_item(b64e_pkg::CMD_ENCODE, 8'h00);
        offer_item(b64e_pkg::CMD_ENCODE, 8'h00);
        offer_item(b64e_pkg::CMD_FINISH, 8'h5A);
        offer_item(b64e_pkg::CMD_FINISH, 8'hFF);
        // '+' in every position, then '/' in every position
        offer_item(b64e_pkg::CMD_ENCODE, 8'hFB);
        offer_item(b64e_pkg::CMD_ENCODE, 8'hEF);
        offer_item(b64e_pkg::CMD_ENCODE, 8'hBE);
        offer_item(b64e_pkg::CMD_ENCODE, 8'hFF);
        offer_item(b64e_pkg::CMD_ENCODE, 8'hFF);
        offer_item(b64e_pkg::CMD_ENCODE, 8'hFF);
        // mixed text-like bytes with both pad lengths
        offer_item(b64e_pkg::CMD_ENCODE, 8'h4D);
        offer_item(b64e_pkg::CMD_ENCODE, 8'h61);
        offer_item(b64e_pkg::CMD_FINISH, 8'h00);
        offer_item(b64e_pkg::CMD_ENCODE, 8'h80);
        offer_item(b64e_pkg::CMD_FINISH, 8'h01);

        // random runs, most of them closed by a finish; the receiver backs off
        // for a long stretch at the start and again halfway through
        bytes_sent  = 0;
        hold_off_go = 1'b1;
        while (bytes_sent < BYTE_TARGET) begin
            if ($urandom_range(0, 9) == 0) begin
                run_len = $urandom_range(10, 20);
            end else begin
                run_len = $urandom_range(0, 6);
            end
            for (i = 0; i < run_len; i++) begin
                offer_item(b64e_pkg::CMD_ENCODE, pick_byte());
            end
            if ($urandom_range(0, 9) != 0) begin
                offer_item(b64e_pkg::CMD_FINISH, 8'($urandom_range(0, 255)));
            end
            if (bytes_sent >= BYTE_TARGET / 2 && bytes_sent < BYTE_TARGET / 2 + 8) begin
                hold_off_go = 1'b1;
            end
        end
        offer_item(b64e_pkg::CMD_FINISH, pick_byte());
        s_tvalid <= 1'b0;

        // let the last transaction reach the pending count first,
        // then let every queued character come out and allow for latency
        @(posedge aclk);
        while (pending_chars != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (fail_count == 0 && pending_chars == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
